// File: src/fhi_pkg.sv
// ----------------------------------------------------------------------------
// fhi_pkg
// shared types and constants for the fixed huffman inflate block
// ----------------------------------------------------------------------------
`default_nettype none
package fhi_pkg;
   localparam logic [1:0] CMD_FEED    = 2'd0;
   localparam logic [1:0] CMD_REQUEST = 2'd1;
   localparam logic [1:0] CMD_START   = 2'd2;

   localparam logic [1:0] ERR_NONE = 2'd0;
   localparam logic [1:0] ERR_CODE = 2'd1;
   localparam logic [1:0] ERR_DIST = 2'd2;

   localparam logic [2:0] PH_SYM   = 3'd0;
   localparam logic [2:0] PH_LEXT  = 3'd1;
   localparam logic [2:0] PH_DCODE = 3'd2;
   localparam logic [2:0] PH_DEXT  = 3'd3;
   localparam logic [2:0] PH_COPY  = 3'd4;
   localparam logic [2:0] PH_DONE  = 3'd5;
   localparam logic [2:0] PH_ERR   = 3'd6;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_valid;
      logic       accepted;
      logic       need_input;
      logic       block_done;
      logic [1:0] error_code;
   } rsp_type;

   function automatic logic [8:0] len_base(input logic [4:0] idx);
      logic [8:0] r;
      case (idx)
         5'd0: r = 9'd3;    5'd1: r = 9'd4;    5'd2: r = 9'd5;    5'd3: r = 9'd6;
         5'd4: r = 9'd7;    5'd5: r = 9'd8;    5'd6: r = 9'd9;    5'd7: r = 9'd10;
         5'd8: r = 9'd11;   5'd9: r = 9'd13;   5'd10: r = 9'd15;  5'd11: r = 9'd17;
         5'd12: r = 9'd19;  5'd13: r = 9'd23;  5'd14: r = 9'd27;  5'd15: r = 9'd31;
         5'd16: r = 9'd35;  5'd17: r = 9'd43;  5'd18: r = 9'd51;  5'd19: r = 9'd59;
         5'd20: r = 9'd67;  5'd21: r = 9'd83;  5'd22: r = 9'd99;  5'd23: r = 9'd115;
         5'd24: r = 9'd131; 5'd25: r = 9'd163; 5'd26: r = 9'd195; 5'd27: r = 9'd227;
         default: r = 9'd258;
      endcase
      return r;
   endfunction

   function automatic logic [2:0] len_extra(input logic [4:0] idx);
      logic [2:0] r;
      if (idx < 5'd8 || idx >= 5'd28) r = 3'd0;
      else r = 3'(((idx - 5'd4) >> 2));
      return r;
   endfunction

   function automatic logic [14:0] dist_base(input logic [4:0] idx);
      logic [14:0] r;
      case (idx)
         5'd0: r = 15'd1;      5'd1: r = 15'd2;      5'd2: r = 15'd3;
         5'd3: r = 15'd4;      5'd4: r = 15'd5;      5'd5: r = 15'd7;
         5'd6: r = 15'd9;      5'd7: r = 15'd13;     5'd8: r = 15'd17;
         5'd9: r = 15'd25;     5'd10: r = 15'd33;    5'd11: r = 15'd49;
         5'd12: r = 15'd65;    5'd13: r = 15'd97;    5'd14: r = 15'd129;
         5'd15: r = 15'd193;   5'd16: r = 15'd257;   5'd17: r = 15'd385;
         5'd18: r = 15'd513;   5'd19: r = 15'd769;   5'd20: r = 15'd1025;
         5'd21: r = 15'd1537;  5'd22: r = 15'd2049;  5'd23: r = 15'd3073;
         5'd24: r = 15'd4097;  5'd25: r = 15'd6145;  5'd26: r = 15'd8193;
         5'd27: r = 15'd12289; 5'd28: r = 15'd16385;
         default: r = 15'd24577;
      endcase
      return r;
   endfunction

   function automatic logic [8:0] rev9(input logic [8:0] v);
      logic [8:0] r;
      for (int i = 0; i < 9; i++) r[i] = v[8 - i];
      return r;
   endfunction
endpackage
`default_nettype wire

// File: src/fhi_window.sv
// ----------------------------------------------------------------------------
// fhi_window
// sliding history window, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module fhi_window #(
   parameter int WINDOW_SIZE = 32768
) (
   input  wire logic                           clock,
   input  wire logic                           wr_en,
   input  wire logic [$clog2(WINDOW_SIZE)-1:0] wr_addr,
   input  wire logic [7:0]                     wr_data,
   input  wire logic [$clog2(WINDOW_SIZE)-1:0] rd_addr,
   output logic      [7:0]                     rd_data
);
   logic [7:0] mem [WINDOW_SIZE];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// File: src/fixed_huffman_inflate_block.sv
// ----------------------------------------------------------------------------
// fixed_huffman_inflate_block
// fixed huffman deflate body decoder with a sliding history window
// ----------------------------------------------------------------------------
// One beat in gives one status beat out. The status beat for a feed or start
// beat is set in the cycle that accepts it and registered. A request runs the
// decode stages one per cycle after the accepting cycle until a byte, a stall,
// the end of block or an error. A copied byte also passes through a read
// state, because the window read is registered. The first byte of a match
// also walks the length and distance stages. The next beat is taken only
// after the status beat has left. The window is a single memory of
// WINDOW_SIZE bytes. It is read only where it was written, so it needs no
// clearing after reset.
`default_nettype none
module fixed_huffman_inflate_block
   import fhi_pkg::*;
#(
   parameter int WINDOW_SIZE = 32768
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // cmd[1:0], in_byte[9:2], zeros
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata    // out_byte, out_valid, accepted,
                                         // need_input, block_done, error_code
);
   localparam int AW = $clog2(WINDOW_SIZE);
   localparam logic [16:0] WS = 17'(WINDOW_SIZE);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_RD   = 2'd2;

   logic [1:0]  st_ff, st_in;
   logic [23:0] store_ff, store_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [2:0]  ph_ff, ph_in;
   logic [8:0]  clen_ff, clen_in;
   logic [15:0] cdist_ff, cdist_in;
   logic [AW-1:0] wpos_ff, wpos_in;
   logic [16:0] fill_ff, fill_in;
   logic [1:0]  err_ff, err_in;
   logic        ovalid_ff, ovalid_in;
   rsp_type     rsp_ff, rsp_in;
   logic [7:0]  rd_data;

   logic          wr_en;
   logic [7:0]    wr_data;
   logic [AW-1:0] rd_addr;

   fhi_window #(.WINDOW_SIZE(WINDOW_SIZE)) u_window (
      .clock(clock), .wr_en(wr_en), .wr_addr(wpos_ff), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   assign req_tready = (st_ff == ST_IDLE) && !ovalid_ff;
   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = {2'b00, rsp_ff.error_code, rsp_ff.block_done, rsp_ff.need_input,
                        rsp_ff.accepted, rsp_ff.out_valid, rsp_ff.out_byte};

   logic [1:0] cmd;
   logic [7:0] in_byte;
   assign cmd     = req_tdata[1:0];
   assign in_byte = req_tdata[9:2];

   logic [8:0] m9;
   logic [6:0] hi;
   logic [8:0] sym;
   logic [3:0] n;
   logic [4:0] lidx, didx;
   logic [2:0] leb;
   logic [3:0] deb;
   logic [16:0] dval;
   logic [AW:0] raddr_full;
   logic [AW-1:0] wpos_next;

   always_comb begin
      m9  = rev9(store_ff[8:0]);
      hi  = m9[8:2];
      if (hi <= 7'd23) n = 4'd7;
      else if (hi <= 7'd99) n = 4'd8;
      else n = 4'd9;
      if (n == 4'd7) sym = 9'd256 + {2'b00, hi};
      else if (hi <= 7'd95) sym = {1'b0, m9[8:1]} - 9'd48;
      else if (n == 4'd8) sym = 9'd280 + ({1'b0, m9[8:1]} - 9'd192);
      else sym = 9'd144 + (m9 - 9'd400);
      lidx = (clen_ff > 9'd28) ? 5'd28 : clen_ff[4:0];
      leb  = len_extra(lidx);
      didx = (cdist_ff > 16'd29) ? 5'd29 : cdist_ff[4:0];
      deb  = (didx < 5'd4) ? 4'd0 : 4'(didx[4:1] - 4'd1);
      dval = {2'b00, dist_base(didx)} + 17'(store_ff[13:0] & ((14'd1 << deb) - 14'd1));
      raddr_full = {1'b0, wpos_ff} + (AW+1)'(WS) - (AW+1)'(cdist_ff);
      if (raddr_full >= (AW+1)'(WS)) rd_addr = AW'(raddr_full - (AW+1)'(WS));
      else rd_addr = AW'(raddr_full);
      wpos_next = ({1'b0, wpos_ff} + 1'b1 >= (AW+1)'(WS)) ? '0 : AW'(wpos_ff + 1'b1);
   end

   always_comb begin
      st_in = st_ff; store_in = store_ff; cnt_in = cnt_ff; ph_in = ph_ff;
      clen_in = clen_ff; cdist_in = cdist_ff; wpos_in = wpos_ff; fill_in = fill_ff;
      err_in = err_ff; ovalid_in = ovalid_ff; rsp_in = rsp_ff;
      wr_en = 1'b0; wr_data = sym[7:0];
      if (ovalid_ff && rsp_tready) ovalid_in = 1'b0;
      case (st_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               rsp_in = '0;
               if (cmd == CMD_FEED) begin
                  if (cnt_ff <= 5'd16) begin
                     store_in = store_ff | (24'(in_byte) << cnt_ff);
                     cnt_in = cnt_ff + 5'd8;
                     rsp_in.accepted = 1'b1;
                  end
               end else if (cmd == CMD_START) begin
                  if (ph_ff != PH_ERR) begin
                     ph_in = PH_SYM; clen_in = '0; cdist_in = '0;
                  end
               end
               if (cmd == CMD_REQUEST) begin
                  st_in = ST_RUN;
               end else begin
                  rsp_in.block_done = (ph_in == PH_DONE);
                  rsp_in.error_code = err_ff;
                  ovalid_in = 1'b1;
               end
            end
         end
         ST_RUN: begin
            logic fin, stall;
            fin = 1'b0; stall = 1'b0;
            case (ph_ff)
               PH_SYM: begin
                  if (cnt_ff < 5'd7 || cnt_ff < 5'(n)) begin
                     stall = 1'b1; fin = 1'b1;
                  end else begin
                     store_in = store_ff >> n;
                     cnt_in = cnt_ff - 5'(n);
                     if (sym < 9'd256) begin
                        wr_en = 1'b1; wr_data = sym[7:0];
                        wpos_in = wpos_next;
                        if (fill_ff < WS) fill_in = fill_ff + 17'd1;
                        rsp_in.out_byte = sym[7:0]; rsp_in.out_valid = 1'b1;
                        fin = 1'b1;
                     end else if (sym == 9'd256) begin
                        ph_in = PH_DONE; fin = 1'b1;
                     end else if (sym > 9'd285) begin
                        err_in = ERR_CODE; ph_in = PH_ERR; fin = 1'b1;
                     end else begin
                        clen_in = sym - 9'd257; ph_in = PH_LEXT;
                     end
                  end
               end
               PH_LEXT: begin
                  if (cnt_ff < 5'(leb)) begin
                     stall = 1'b1; fin = 1'b1;
                  end else begin
                     clen_in = len_base(lidx) + 9'(store_ff[4:0] & ((5'd1 << leb) - 5'd1));
                     store_in = store_ff >> leb;
                     cnt_in = cnt_ff - 5'(leb);
                     ph_in = PH_DCODE;
                  end
               end
               PH_DCODE: begin
                  if (cnt_ff < 5'd5) begin
                     stall = 1'b1; fin = 1'b1;
                  end else begin
                     store_in = store_ff >> 5;
                     cnt_in = cnt_ff - 5'd5;
                     if (m9[8:4] > 5'd29) begin
                        err_in = ERR_CODE; ph_in = PH_ERR; fin = 1'b1;
                     end else begin
                        cdist_in = 16'(m9[8:4]); ph_in = PH_DEXT;
                     end
                  end
               end
               PH_DEXT: begin
                  if (cnt_ff < 5'(deb)) begin
                     stall = 1'b1; fin = 1'b1;
                  end else begin
                     store_in = store_ff >> deb;
                     cnt_in = cnt_ff - 5'(deb);
                     if (dval > fill_ff) begin
                        err_in = ERR_DIST; ph_in = PH_ERR; fin = 1'b1;
                     end else begin
                        cdist_in = 16'(dval); ph_in = PH_COPY;
                     end
                  end
               end
               PH_COPY: begin
                  if (clen_ff == '0 || cdist_ff == '0 || 17'(cdist_ff) > fill_ff) begin
                     ph_in = PH_SYM;
                  end else begin
                     st_in = ST_RD;
                  end
               end
               default: fin = 1'b1;
            endcase
            if (fin) begin
               st_in = ST_IDLE;
               rsp_in.need_input = stall;
               rsp_in.block_done = (ph_in == PH_DONE);
               rsp_in.error_code = err_in;
               ovalid_in = 1'b1;
            end
         end
         ST_RD: begin
            wr_en = 1'b1; wr_data = rd_data;
            wpos_in = wpos_next;
            if (fill_ff < WS) fill_in = fill_ff + 17'd1;
            clen_in = clen_ff - 9'd1;
            if (clen_ff == 9'd1) ph_in = PH_SYM;
            rsp_in.out_byte = rd_data; rsp_in.out_valid = 1'b1;
            rsp_in.block_done = 1'b0;
            rsp_in.error_code = err_ff;
            ovalid_in = 1'b1;
            st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE; store_ff <= '0; cnt_ff <= '0; ph_ff <= PH_SYM;
         clen_ff <= '0; cdist_ff <= '0; wpos_ff <= '0; fill_ff <= '0;
         err_ff <= ERR_NONE; ovalid_ff <= 1'b0;
      end else begin
         st_ff <= st_in; store_ff <= store_in; cnt_ff <= cnt_in; ph_ff <= ph_in;
         clen_ff <= clen_in; cdist_ff <= cdist_in; wpos_ff <= wpos_in;
         fill_ff <= fill_in; err_ff <= err_in; ovalid_ff <= ovalid_in;
      end
      rsp_ff <= rsp_in;
   end
endmodule
`default_nettype wire

// File: src/fhi_checker.sv
// ----------------------------------------------------------------------------
// fhi_checker
// port level checks for the fixed huffman inflate block
// ----------------------------------------------------------------------------
`default_nettype none
module fhi_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [15:0] req_tdata,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat dropped or changed while stalled");
   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tdata[13:12] != 2'd0 ##1
      rsp_tvalid && rsp_tready |-> rsp_tdata[13:12] != 2'd0)
      else $error("sticky error cleared");
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[8] && rsp_tdata[9]) && !(rsp_tdata[8] && rsp_tdata[10]))
      else $error("conflicting status flags");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request taken while a response is pending");
   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[8] |-> rsp_tdata[7:0] == 8'd0)
      else $error("byte without valid flag");
endmodule

bind fixed_huffman_inflate_block fhi_checker u_fhi_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .req_tdata(req_tdata), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata)
);
`default_nettype wire

// File: tb/sv/fhi_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fhi_scoreboard
// watches both streams of the inflate block, predicts each status beat from
// its own copy of the bit store, decode phase and history window, and
// compares every returned beat field by field with the oldest prediction
// ----------------------------------------------------------------------------
module fhi_scoreboard
   import fhi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,
   output int          failures,
   output int          outstanding
);
   typedef struct {
      logic [7:0] out_byte;
      logic       out_valid;
      logic       accepted;
      logic       need_input;
      logic       block_done;
      logic [1:0] error_code;
   } status_type;

   localparam int WIN = 32768;

   int lbase[29] = '{3, 4, 5, 6, 7, 8, 9, 10, 11, 13, 15, 17, 19, 23, 27, 31,
                     35, 43, 51, 59, 67, 83, 99, 115, 131, 163, 195, 227, 258};
   int lext[29] = '{0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 1, 1, 2, 2, 2, 2,
                    3, 3, 3, 3, 4, 4, 4, 4, 5, 5, 5, 5, 0};
   int dbase[30] = '{1, 2, 3, 4, 5, 7, 9, 13, 17, 25, 33, 49, 65, 97, 129, 193,
                     257, 385, 513, 769, 1025, 1537, 2049, 3073, 4097, 6145,
                     8193, 12289, 16385, 24577};

   logic [23:0] store;
   int          nbits;
   logic [2:0]  ph;
   int          run_len;
   int          run_dist;
   logic [7:0]  window [WIN];
   int          wpos;
   int          filled;
   logic [1:0]  err;
   status_type  pending [$];

   function automatic int take_msb(input int n);
      int v;
      v = 0;
      for (int i = 0; i < n; i++) v = (v << 1) | store[i];
      return v;
   endfunction

   function automatic int take_lsb(input int n);
      return int'(store & ((24'd1 << n) - 24'd1));
   endfunction

   function automatic void drop(input int n);
      store = store >> n;
      nbits -= n;
   endfunction

   function automatic void emit(input logic [7:0] b);
      window[wpos] = b;
      wpos = (wpos + 1 >= WIN) ? 0 : wpos + 1;
      if (filled < WIN) filled++;
   endfunction

   function automatic void fail_with(input logic [1:0] e);
      err = e;
      ph = PH_ERR;
   endfunction

   function automatic void decode_step(output logic got, output logic [7:0] b,
                                       output logic stall);
      int hi, n, raw, code, idx, eb, d;
      got = 0;
      b = 0;
      stall = 0;
      forever begin
         case (ph)
            PH_SYM: begin
               if (nbits < 7) begin
                  stall = 1;
                  return;
               end
               hi = take_msb(7);
               n = (hi <= 23) ? 7 : (hi <= 99) ? 8 : 9;
               if (nbits < n) begin
                  stall = 1;
                  return;
               end
               raw = take_msb(n);
               drop(n);
               if (n == 7) code = 256 + raw;
               else if (hi <= 95) code = raw - 48;
               else if (n == 8) code = 280 + raw - 192;
               else code = 144 + raw - 400;
               if (code < 256) begin
                  emit(code[7:0]);
                  got = 1;
                  b = code[7:0];
                  return;
               end
               if (code == 256) begin
                  ph = PH_DONE;
                  return;
               end
               if (code > 285) begin
                  fail_with(ERR_CODE);
                  return;
               end
               run_len = code - 257;
               ph = PH_LEXT;
            end
            PH_LEXT: begin
               idx = (run_len > 28) ? 28 : run_len;
               eb = lext[idx];
               if (nbits < eb) begin
                  stall = 1;
                  return;
               end
               run_len = lbase[idx] + take_lsb(eb);
               drop(eb);
               ph = PH_DCODE;
            end
            PH_DCODE: begin
               if (nbits < 5) begin
                  stall = 1;
                  return;
               end
               d = take_msb(5);
               drop(5);
               if (d > 29) begin
                  fail_with(ERR_CODE);
                  return;
               end
               run_dist = d;
               ph = PH_DEXT;
            end
            PH_DEXT: begin
               idx = (run_dist > 29) ? 29 : run_dist;
               eb = (idx < 4) ? 0 : idx / 2 - 1;
               if (nbits < eb) begin
                  stall = 1;
                  return;
               end
               d = dbase[idx] + take_lsb(eb);
               drop(eb);
               if (d > filled) begin
                  fail_with(ERR_DIST);
                  return;
               end
               run_dist = d;
               ph = PH_COPY;
            end
            PH_COPY: begin
               if (run_len == 0 || run_dist == 0 || run_dist > filled) begin
                  ph = PH_SYM;
               end else begin
                  b = window[(wpos + WIN - run_dist) % WIN];
                  emit(b);
                  run_len--;
                  if (run_len == 0) ph = PH_SYM;
                  got = 1;
                  return;
               end
            end
            default: return;
         endcase
      end
   endfunction

   function automatic status_type predict(input logic [1:0] cmd, input logic [7:0] din);
      status_type s;
      s = '{default: 0};
      case (cmd)
         CMD_FEED: begin
            if (nbits <= 16) begin
               store = store | (24'(din) << nbits);
               nbits += 8;
               s.accepted = 1;
            end
         end
         CMD_REQUEST: decode_step(s.out_valid, s.out_byte, s.need_input);
         CMD_START: begin
            if (ph != PH_ERR) begin
               ph = PH_SYM;
               run_len = 0;
               run_dist = 0;
            end
         end
         default: ;
      endcase
      s.block_done = (ph == PH_DONE);
      s.error_code = err;
      return s;
   endfunction

   always @(posedge clock) begin
      status_type e;
      if (reset) begin
         store = 0;
         nbits = 0;
         ph = PH_SYM;
         run_len = 0;
         run_dist = 0;
         wpos = 0;
         filled = 0;
         err = ERR_NONE;
         pending.delete();
         failures <= 0;
         outstanding <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending.size() == 0) begin
               $error("status beat with no prediction waiting: %h", rsp_tdata);
               failures <= failures + 1;
            end else begin
               e = pending.pop_front();
               if (rsp_tdata[7:0] !== e.out_byte ||
                   rsp_tdata[8] !== e.out_valid ||
                   rsp_tdata[9] !== e.accepted ||
                   rsp_tdata[10] !== e.need_input ||
                   rsp_tdata[11] !== e.block_done ||
                   rsp_tdata[13:12] !== e.error_code ||
                   rsp_tdata[15:14] !== 2'b00)
                  failures <= failures + 1;
               if (rsp_tdata[7:0] !== e.out_byte)
                  $error("out_byte expected %h got %h", e.out_byte, rsp_tdata[7:0]);
               if (rsp_tdata[8] !== e.out_valid)
                  $error("out_valid expected %b got %b", e.out_valid, rsp_tdata[8]);
               if (rsp_tdata[9] !== e.accepted)
                  $error("accepted expected %b got %b", e.accepted, rsp_tdata[9]);
               if (rsp_tdata[10] !== e.need_input)
                  $error("need_input expected %b got %b", e.need_input, rsp_tdata[10]);
               if (rsp_tdata[11] !== e.block_done)
                  $error("block_done expected %b got %b", e.block_done, rsp_tdata[11]);
               if (rsp_tdata[13:12] !== e.error_code)
                  $error("error_code expected %0d got %0d", e.error_code,
                         rsp_tdata[13:12]);
               if (rsp_tdata[15:14] !== 2'b00)
                  $error("padding expected 0 got %b", rsp_tdata[15:14]);
            end
         end
         if (req_tvalid && req_tready)
            pending.push_back(predict(req_tdata[1:0], req_tdata[9:2]));
         outstanding <= pending.size();
      end
   end
endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives a continuous fixed huffman bit stream of literals, overlapping and
// long matches and block ends into the inflate block, then closes with one
// corrupt symbol and random noise, under varying idle and stall pressure
// ----------------------------------------------------------------------------
module testbench;
   import fhi_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   int          failures;
   int          outstanding;
   int          tx_idle;
   int          rx_stall;
   int          beats;
   int          gen_fill;
   logic        first_block;
   logic        bits [$];
   logic [7:0]  stream [$];

   fixed_huffman_inflate_block dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   fhi_scoreboard checker_i (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .failures(failures), .outstanding(outstanding)
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("FAIL");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= rx_stall);
   end

   task automatic push_msb(input int v, input int n);
      for (int i = n - 1; i >= 0; i--) bits.push_back(v[i]);
   endtask

   task automatic push_lsb(input int v, input int n);
      for (int i = 0; i < n; i++) bits.push_back(v[i]);
   endtask

   task automatic put_symbol(input int code);
      if (code < 144) push_msb(code + 48, 8);
      else if (code < 256) push_msb(code - 144 + 400, 9);
      else if (code < 280) push_msb(code - 256, 7);
      else push_msb(code - 280 + 192, 8);
   endtask

   task automatic put_literal(input int v);
      put_symbol(v);
      gen_fill++;
   endtask

   // alt picks code 284 with all extra bits set for a length of 258
   task automatic put_match(input int len, input int offset, input logic alt);
      int li, di;
      li = 27;
      if (len == 258 && !alt) li = 28;
      else while (li > 0 && len_base(5'(li)) > len) li--;
      put_symbol(257 + li);
      push_lsb(len - len_base(5'(li)), len_extra(5'(li)));
      di = 29;
      while (di > 0 && dist_base(5'(di)) > offset) di--;
      push_msb(di, 5);
      push_lsb(offset - dist_base(5'(di)), (di < 4) ? 0 : di / 2 - 1);
      gen_fill += len;
   endtask

   task automatic make_block(input logic corrupt);
      int n, len, offset, kind;
      if (first_block) begin
         first_block = 0;
         put_literal(0);
         put_literal(143);
         put_literal(144);
         put_literal(255);
         put_match(3, 1, 0);
         put_match(258, 4, 0);
         put_match(258, 2, 1);
         put_match(10, 7, 0);
      end else begin
         n = $urandom_range(1, 12);
         repeat (n) begin
            if (gen_fill == 0 || $urandom_range(2) != 0) begin
               put_literal($urandom_range(255));
            end else begin
               len = ($urandom_range(4) != 0) ? $urandom_range(3, 18)
                                              : $urandom_range(3, 258);
               offset = ($urandom_range(3) != 0)
                  ? $urandom_range(1, (gen_fill < 16) ? gen_fill : 16)
                  : $urandom_range(1, (gen_fill < 32768) ? gen_fill : 32768);
               put_match(len, offset, 1'($urandom_range(1)));
            end
         end
      end
      if (corrupt) begin
         kind = $urandom_range(2);
         if (kind == 2 && gen_fill >= 24577) kind = 0;
         case (kind)
            0: put_symbol($urandom_range(286, 287));
            1: begin
               put_symbol(257);
               push_msb($urandom_range(30, 31), 5);
            end
            default: begin
               put_symbol(257);
               push_msb(29, 5);
               push_lsb($urandom_range(8191), 13);
            end
         endcase
      end else begin
         put_symbol(256);
      end
      while (bits.size() >= 8) begin
         logic [7:0] b;
         for (int i = 0; i < 8; i++) b[i] = bits.pop_front();
         stream.push_back(b);
      end
   endtask

   task automatic send(input logic [1:0] cmd, input logic [7:0] din,
                       output logic [15:0] status);
      if (beats < 450) begin
         tx_idle = 0;
         rx_stall = 0;
      end else if (beats < 900) begin
         tx_idle = 54;
         rx_stall = 0;
      end else if (beats < 1350) begin
         tx_idle = 0;
         rx_stall = 54;
      end else begin
         tx_idle = 29;
         rx_stall = 29;
      end
      while ($urandom_range(99) < tx_idle) @(posedge clock);
      req_tvalid <= 1;
      req_tdata <= {6'd0, din, cmd};
      do @(posedge clock); while (!req_tready);
      req_tvalid <= 0;
      do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      status = rsp_tdata;
      beats++;
   endtask

   initial begin
      logic [15:0] st;
      logic        stalled;
      logic        done;
      logic        broken;
      int          guard;
      reset = 1;
      req_tvalid = 0;
      req_tdata = 0;
      tx_idle = 0;
      rx_stall = 0;
      beats = 0;
      gen_fill = 0;
      first_block = 1;
      stalled = 0;
      done = 0;
      broken = 0;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      guard = 0;
      while (!broken && guard < 6000) begin
         guard++;
         if (stream.size() < 4) make_block(beats >= 1400);
         if (done) begin
            send(CMD_START, 8'($urandom_range(255)), st);
            done = st[11];
         end else if ($urandom_range(39) == 0) begin
            send(2'd3, 8'($urandom_range(255)), st);
         end else if (stalled || $urandom_range(2) == 0) begin
            send(CMD_FEED, stream[0], st);
            if (st[9]) begin
               void'(stream.pop_front());
               stalled = 0;
            end
         end else begin
            send(CMD_REQUEST, 8'($urandom_range(255)), st);
            stalled = st[10];
            done = st[11];
         end
         broken = (st[13:12] != ERR_NONE);
      end
      repeat (150) begin
         send(2'($urandom_range(3)), 8'($urandom_range(255)), st);
      end
      guard = 0;
      while (outstanding != 0 && guard < 10000) begin
         @(posedge clock);
         guard++;
      end
      repeat (20) @(posedge clock);
      if (failures == 0 && outstanding == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
